// ===== rtl/core/cf32_pkg.sv =====
package cf32_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [7:0] EXP_BIAS  = 8'd127;
	localparam int         MAX_ALIGN = 31;

	// work kind after the align stage
	typedef enum logic [1:0] {
		K1_DIRECT,
		K1_ADD,
		K1_SUB,
		K1_MUL
	} kind1_t;

	// work kind after the add stage
	typedef enum logic [1:0] {
		K2_DIRECT,
		K2_CARRY,
		K2_LZ
	} kind2_t;

	typedef struct packed {
		kind2_t      kind;
		logic [31:0] word;
		logic        sign;
		logic [7:0]  expo;
		logic [31:0] mant;
	} stage2_t;

endpackage

// ===== rtl/core/custom_float32_add_sub_mul_unit.sv =====
// Custom 32-bit float add / subtract / multiply unit.
// Word format: sign in bit 31, fraction in bits 30..8 below a hidden one,
// exponent biased by 127 in bits 7..0.
// Input channel: in_valid / in_stall carry req_type, operand_a, operand_b;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry result_word the same way.
// Pipeline: three register stages.
//   s1: exponent compare, mantissa alignment shift, 16x16 product.
//   s2: mantissa add or magnitude subtract with sign select.
//   s3: leading-one normalize and pack into the output register.
// Throughput is one operation per cycle while out_stall stays low; a result
// passes the s1, s2 and s3 registers before out_valid rises.
// Stall: a stage holds when the next stage is full and held; out_stall
// backs up through the stages, and in_stall rises only when all three
// stages hold data and out_stall is high. Nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline; out_valid drops at once.
// Exponents wrap modulo 256; no flags are produced.
module custom_float32_add_sub_mul_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_word
);
	import cf32_pkg::*;

	// pipeline handshake
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || !out_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// ---------------- stage 1: align / multiply ----------------
	logic [7:0]  ea, eb;
	logic [8:0]  d;
	logic        far_a, far_b, eff_sub;
	logic [4:0]  sh;
	logic [31:0] ma0, mb0, ma_al, mb_al;
	logic [31:0] prod;
	logic [7:0]  e_mul;

	kind1_t      kind_n;
	logic [31:0] word_n;
	logic        sign_n;
	logic [7:0]  e_n;
	logic [31:0] ma_n, mb_n;

	assign ea      = operand_a[7:0];
	assign eb      = operand_b[7:0];
	assign d       = {1'b0, ea} - {1'b0, eb};
	assign far_a   = !d[8] && (d > 9'(MAX_ALIGN));
	assign far_b   = d[8] && (d < 9'(-MAX_ALIGN));
	assign eff_sub = operand_a[31] ^ operand_b[31] ^ (req_type == OP_SUB);
	assign sh      = d[8] ? 5'(-d) : d[4:0];
	// add pre-shifts by one to leave room for the carry
	assign ma0     = eff_sub ? {1'b1, operand_a[30:8], 8'b0} : {2'b01, operand_a[30:8], 7'b0};
	assign mb0     = eff_sub ? {1'b1, operand_b[30:8], 8'b0} : {2'b01, operand_b[30:8], 7'b0};
	assign ma_al   = d[8] ? (ma0 >> sh) : ma0;
	assign mb_al   = d[8] ? mb0 : (mb0 >> sh);
	assign prod    = {1'b1, operand_a[30:16]} * {1'b1, operand_b[30:16]};
	assign e_mul   = ea + eb - EXP_BIAS;

	always_comb begin
		kind_n = K1_DIRECT;
		word_n = '0;
		sign_n = operand_a[31];
		e_n    = d[8] ? eb : ea;
		ma_n   = ma_al;
		mb_n   = mb_al;
		case (req_type) inside
			OP_MUL: begin
				sign_n = operand_a[31] ^ operand_b[31];
				e_n    = e_mul;
				ma_n   = prod;
				if (operand_a == '0 || operand_b == '0) kind_n = K1_DIRECT;
				else kind_n = K1_MUL;
			end
			OP_ADD, OP_SUB: begin
				if (!eff_sub) begin
					if (far_a) word_n = {operand_a[31], operand_a[30:0]};
					else if (far_b) word_n = {operand_a[31], operand_b[30:0]};
					kind_n = (far_a || far_b) ? K1_DIRECT : K1_ADD;
				end else begin
					if (far_a) word_n = operand_a;
					else if (far_b) word_n = {!operand_a[31], operand_b[30:0]};
					kind_n = (far_a || far_b) ? K1_DIRECT : K1_SUB;
				end
			end
			default: kind_n = K1_DIRECT;
		endcase
	end

	kind1_t      kind_s1;
	logic [31:0] word_s1;
	logic        sign_s1;
	logic [7:0]  e_s1;
	logic [31:0] ma_s1, mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			kind_s1 <= kind_n;
			word_s1 <= word_n;
			sign_s1 <= sign_n;
			e_s1    <= e_n;
			ma_s1   <= ma_n;
			mb_s1   <= mb_n;
		end
	end

	// ---------------- stage 2: add / subtract ----------------
	stage2_t st2_n, st_s2;

	always_comb begin
		st2_n.kind = K2_DIRECT;
		st2_n.word = word_s1;
		st2_n.sign = sign_s1;
		st2_n.expo = e_s1;
		st2_n.mant = ma_s1;
		case (kind_s1)
			K1_ADD: begin
				st2_n.kind = K2_CARRY;
				st2_n.mant = ma_s1 + mb_s1;
			end
			K1_MUL: st2_n.kind = K2_CARRY;
			K1_SUB: begin
				if (ma_s1 > mb_s1) begin
					st2_n.kind = K2_LZ;
					st2_n.mant = ma_s1 - mb_s1;
				end else if (ma_s1 < mb_s1) begin
					st2_n.kind = K2_LZ;
					st2_n.mant = mb_s1 - ma_s1;
					st2_n.sign = !sign_s1;
				end else begin
					st2_n.word = '0;
				end
			end
			default: st2_n.kind = K2_DIRECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) st_s2 <= st2_n;
	end

	// ---------------- stage 3: normalize / pack ----------------
	logic [31:0] res_n, res_s3;

	cf32_norm u_norm (
		.st     (st_s2),
		.result (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) res_s3 <= res_n;
	end

	assign out_valid   = v_s3;
	assign result_word = res_s3;

`ifndef SYNTHESIS
	// input held back only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3))
		else $error("input stalled with a free stage");

	// add operands carry a clear top bit for the carry
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && kind_s1 == K1_ADD) |-> (!ma_s1[31] && !mb_s1[31]))
		else $error("add mantissa without carry headroom");

	// a normalize-by-search item never holds a zero difference
	a_lz_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && st_s2.kind == K2_LZ) |-> (st_s2.mant != '0))
		else $error("zero difference sent to normalize");

	// a held output stage keeps stage 2 frozen too
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && out_stall) |=> (v_s2 && $stable(st_s2)))
		else $error("stage 2 moved under stall");
`endif
endmodule

// ===== rtl/core/cf32_norm.sv =====
module cf32_norm (
	input  cf32_pkg::stage2_t st,
	output logic [31:0]       result
);
	import cf32_pkg::*;

	logic [4:0]  lz;
	logic        found;
	logic [31:0] mn;
	logic [7:0]  e_inc;
	logic [7:0]  e_dec;

	// leading-one search
	always_comb begin
		lz    = '0;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && st.mant[i]) begin
				lz    = 5'(31 - i);
				found = 1'b1;
			end
		end
	end

	assign mn    = st.mant << lz;
	assign e_inc = st.expo + 8'd1;
	assign e_dec = st.expo - {3'b000, lz};

	always_comb begin
		case (st.kind)
			K2_CARRY: begin
				if (st.mant[31]) result = {st.sign, st.mant[30:8], e_inc};
				else result = {st.sign, st.mant[29:7], st.expo};
			end
			K2_LZ:    result = {st.sign, mn[30:8], e_dec};
			default:  result = st.word;
		endcase
	end
endmodule

// ===== sim/tb_custom_float32_add_sub_mul_unit.sv =====
`timescale 1ns / 1ps

// Testbench for the custom float add / subtract / multiply unit.
// Stimulus is driven in transfers on the input channel; every accepted
// transfer pushes a predicted result word into a queue, and a monitor
// compares each output transfer against the oldest prediction.
module tb_custom_float32_add_sub_mul_unit;
	import cf32_pkg::*;

	localparam logic [31:0] NEG_BIT   = 32'h8000_0000;
	localparam logic [31:0] FRAC_MASK = 32'h7FFF_FF00;
	localparam logic [31:0] EXP_MASK  = 32'h0000_00FF;
	localparam logic [31:0] HIDDEN    = 32'h8000_0000;
	localparam logic [1:0]  OP_NONE   = 2'd3;  // unused code, yields 0
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_word;

	logic [31:0] expected_words[$];
	int          mismatch_count;
	int          idle_cycles;
	bit          idle_enable;   // random gaps on both sides when set
	bit          stim_done;

	custom_float32_add_sub_mul_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_word(result_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor: magnitude add for equal effective signs.
	// ---------------------------------------------------------------
	function automatic logic [31:0] add_magnitudes(logic [31:0] sgn, logic [31:0] a,
			logic [31:0] b);
		int          exp_gap;
		logic [31:0] ma, mb, ex;
		exp_gap = int'(a[7:0]) - int'(b[7:0]);
		if (exp_gap > MAX_ALIGN) return sgn | (a & ~NEG_BIT);
		if (exp_gap < -MAX_ALIGN) return sgn | (b & ~NEG_BIT);
		ma = ((a & FRAC_MASK) | HIDDEN) >> 1;
		mb = ((b & FRAC_MASK) | HIDDEN) >> 1;
		if (exp_gap < 0) begin
			ma = ma >> (-exp_gap);
			ex = b & EXP_MASK;
		end else begin
			mb = mb >> exp_gap;
			ex = a & EXP_MASK;
		end
		ma = ma + mb;
		// carry into the top bit bumps the exponent, else renormalize by one
		if (ma[31]) ex = (ex + 1) & EXP_MASK;
		else ma = ma << 1;
		return sgn | ex | (ma & FRAC_MASK);
	endfunction

	// Magnitude subtract for differing effective signs.
	function automatic logic [31:0] sub_magnitudes(logic [31:0] sgn, logic [31:0] a,
			logic [31:0] b);
		int          exp_gap;
		int          lead_zeros;
		logic [31:0] ma, mb, ex, diff, rsgn;
		exp_gap = int'(a[7:0]) - int'(b[7:0]);
		lead_zeros = 0;
		if (exp_gap > MAX_ALIGN) return a;
		if (exp_gap < -MAX_ALIGN) return (sgn ^ NEG_BIT) | (b & ~NEG_BIT);
		ma = (a & FRAC_MASK) | HIDDEN;
		mb = (b & FRAC_MASK) | HIDDEN;
		if (exp_gap < 0) begin
			ma = ma >> (-exp_gap);
			ex = b & EXP_MASK;
		end else begin
			mb = mb >> exp_gap;
			ex = a & EXP_MASK;
		end
		if (ma > mb) begin
			diff = ma - mb;
			rsgn = sgn;
		end else if (ma < mb) begin
			diff = mb - ma;
			rsgn = sgn ^ NEG_BIT;
		end else begin
			return 32'd0;   // exact cancellation
		end
		while (!diff[31]) begin
			diff = diff << 1;
			lead_zeros++;
		end
		ex = (ex - lead_zeros) & EXP_MASK;
		return rsgn | ex | (diff & FRAC_MASK);
	endfunction

	// 16x16 truncated mantissa product; only an all-zero word counts as zero.
	function automatic logic [31:0] multiply_words(logic [31:0] a, logic [31:0] b);
		logic [31:0] prod, ex;
		if (a == 32'd0 || b == 32'd0) return 32'd0;
		prod = (((a & FRAC_MASK) | HIDDEN) >> 16) * (((b & FRAC_MASK) | HIDDEN) >> 16);
		ex = ((a & EXP_MASK) + (b & EXP_MASK) - EXP_BIAS) & EXP_MASK;
		if (prod[31]) ex = (ex + 1) & EXP_MASK;
		else prod = prod << 1;
		return ((a ^ b) & NEG_BIT) | ex | (prod & FRAC_MASK);
	endfunction

	function automatic logic [31:0] predict_result(logic [1:0] op, logic [31:0] a,
			logic [31:0] b);
		logic [31:0] sa, sb;
		if (op == OP_MUL) return multiply_words(a, b);
		if (op == OP_NONE) return 32'd0;
		sa = a & NEG_BIT;
		// subtraction folds into an effective sign flip of operand b
		sb = (b & NEG_BIT) ^ ((op == OP_SUB) ? NEG_BIT : 32'd0);
		if (sa == sb) return add_magnitudes(sa, a, b);
		return sub_magnitudes(sa, a, b);
	endfunction

	// ---------------------------------------------------------------
	// Reporting
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what);
		$display("mismatch @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// Sender: one transfer, optional random gap before it.
	// valid is lowered only when a gap follows, so it never toggles twice
	// in one time step.
	// ---------------------------------------------------------------
	task automatic send_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
		while (idle_enable && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_words.push_back(predict_result(op, a, b));
	endtask

	task automatic finish_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver stall: random in idle mode, never otherwise.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= idle_enable && ($urandom_range(99) < 24);
		end
	end

	// Result monitor: compare each output transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", result_word));
			end else begin
				logic [31:0] want;
				want = expected_words.pop_front();
				if (result_word !== want)
					report_mismatch($sformatf("result_word got %h want %h",
						result_word, want));
			end
		end
	end

	// Watchdog: cycles without any transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (!stim_done || expected_words.size() != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	function automatic logic [31:0] make_word(bit sgn, logic [22:0] frac, logic [7:0] ex);
		return {sgn, frac, ex};
	endfunction

	task automatic test_directed();
		send_item(OP_ADD, 32'd0, 32'd0);                  // zero word in add
		send_item(OP_SUB, 32'd0, 32'd0);                  // equal mantissas -> 0
		send_item(OP_MUL, 32'd0, 32'h3F80_007F);          // zero in multiply
		send_item(OP_MUL, 32'h8000_0000, 32'h0000_007F);  // negative zero is not zero
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // exponent wrap on carry
		send_item(OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_MUL, 32'h0000_0001, 32'h0000_0001);  // exponent underflow
		send_item(OP_ADD, make_word(0, 0, 8'd200), make_word(0, 0, 8'd100)); // far apart
		send_item(OP_ADD, make_word(1, 5, 8'd10), make_word(1, 7, 8'd200));
		send_item(OP_SUB, make_word(0, 9, 8'd200), make_word(0, 3, 8'd10));
		send_item(OP_SUB, make_word(1, 9, 8'd10), make_word(1, 3, 8'd200));
		send_item(OP_ADD, make_word(0, 1, 8'd131), make_word(0, 2, 8'd100)); // exactly 31
		send_item(OP_ADD, make_word(0, 1, 8'd132), make_word(0, 2, 8'd100)); // 32
		send_item(OP_SUB, make_word(1, 23'h1234, 8'd127), make_word(0, 23'h55, 8'd127));
		send_item(OP_ADD, make_word(1, 23'h1234, 8'd127), make_word(0, 23'h1235, 8'd127));
		send_item(OP_SUB, make_word(0, 23'h400000, 8'd127),
			make_word(0, 23'h3FFFFF, 8'd127));                // deep renormalize
		send_item(OP_NONE, 32'hDEAD_BEEF, 32'h1234_5678);  // unused code
		send_item(OP_MUL, make_word(0, 23'h7FFFFF, 8'd127), make_word(1, 0, 8'd127));
		send_item(OP_ADD, make_word(0, 23'h7FFFFF, 8'd0), make_word(0, 23'h7FFFFF, 8'd255));
	endtask

	// Random operands: mostly close exponents so the arithmetic paths dominate.
	function automatic logic [31:0] random_operand(logic [7:0] base);
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9)) inside
			0: w = 32'd0;
			1, 2: ;                                    // fully random word
			default: w[7:0] = base + 8'($urandom_range(40)) - 8'd20;
		endcase
		return w;
	endfunction

	task automatic test_random(int count);
		logic [7:0] base;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			base = 8'($urandom);
			op = ($urandom_range(29) == 0) ? OP_NONE : 2'($urandom_range(2));
			send_item(op, random_operand(base), random_operand(base));
		end
	endtask

	task automatic test_back_to_back(int count);
		idle_enable = 1'b0;
		test_random(count);
		idle_enable = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		stim_done = 1'b0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = OP_ADD;
		operand_a = '0;
		operand_b = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200);
		test_back_to_back(100);
		test_random(150);
		finish_sending();
		stim_done = 1'b1;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/cf32_pkg.sv
rtl/core/cf32_norm.sv
rtl/core/custom_float32_add_sub_mul_unit.sv
sim/tb_custom_float32_add_sub_mul_unit.sv
